/* rtl/nasc_pkg.sv */
// shared types, widths and constants of the normalized arctangent soft clipper
package nasc_pkg;

    localparam int DATA_W = 24;
    localparam int CFG_W = 16;
    localparam int FRAC_W = 20;
    localparam int MAG_W = CFG_W + DATA_W;
    localparam int XY_W = 44;
    localparam int Z_W = 33;
    localparam int B_W = 31;
    localparam int PROD_W = CFG_W + B_W;
    localparam int NUM_W = PROD_W + 6;
    localparam int QUO_W = 26;
    localparam int DS_W = B_W + QUO_W;

    localparam int ANGLE_STAGES_DEF = 20;

    localparam logic [0:0] REG_DRIVE = 1'b0;
    localparam logic [0:0] REG_CEILING = 1'b1;

    localparam logic [CFG_W-1:0] DRIVE_RESET = 16'd256;
    localparam logic [CFG_W-1:0] CEILING_RESET = 16'd32768;

    localparam logic [XY_W-1:0] X_START = XY_W'(64'd1 << 28);

    localparam logic [QUO_W-1:0] SAT_POS = QUO_W'(32'd8388607);
    localparam logic [QUO_W-1:0] SAT_NEG = QUO_W'(32'd8388608);

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } vec_t;

    typedef struct packed {
        logic neg;
        logic zero;
        vec_t va;
        vec_t vb;
    } cordic_t;

    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [NUM_W-1:0] r;
        logic [B_W-1:0]   b;
        logic [QUO_W-1:0] q;
    } div_t;

endpackage

/* rtl/nasc_cordic_cell.sv */
// one vectoring cordic cell working on the sample lane and the drive lane
module nasc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nasc_pkg::cordic_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nasc_pkg::cordic_t out_data
);
    import nasc_pkg::*;

    localparam logic signed [Z_W-1:0] ANG = $signed(Z_W'(ATAN_TAB[STAGE]));

    logic    out_valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    function automatic vec_t cordic_rot(input vec_t v);
        vec_t r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = $signed(v.x) >>> STAGE;
        ys = $signed(v.y) >>> STAGE;
        r = v;
        if (!v.y[XY_W-1])
        begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + ANG;
        end
        else
        begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - ANG;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next = in_data;
        data_next.va = cordic_rot(in_data.va);
        data_next.vb = cordic_rot(in_data.vb);
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/nasc_div_cell.sv */
// one restoring division cell, the top cell flags quotient overflow
module nasc_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nasc_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output nasc_pkg::div_t out_data
);
    import nasc_pkg::*;

    logic             out_valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [DS_W-1:0]  bs;
    logic [DS_W-1:0]  rx;
    logic             ge;

    always_comb
    begin
        bs = DS_W'(in_data.b) << SHIFT;
        rx = DS_W'(in_data.r);
        ge = rx >= bs;
        data_next = in_data;
        if (SHIFT == QUO_W)
        begin
            data_next.sat = ge;
        end
        else if (ge)
        begin
            data_next.r = NUM_W'(rx - bs);
            data_next.q = in_data.q | (QUO_W'(1) << SHIFT);
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/normalized_atan_soft_clipper.sv */
// Normalized arctangent soft clipper: each Q4.20 sample x becomes
// ceiling * atan(k*|x|) / atan(k) with the sign of x, rounded to nearest and
// saturated to 24 bits. One sample is accepted every cycle unless stalled; the
// pipeline holds the row of ANGLE_STAGES cordic cells plus the row of 27
// restoring division cells and five registers for input, drive product,
// ceiling product, rounding add and output.
// Every stage holds its own request, so stalls only back up as far as needed.
// Drive and ceiling are read at different points along the pipeline, so write
// them only while no sample is in flight.
module normalized_atan_soft_clipper #(
    parameter int ANGLE_STAGES = nasc_pkg::ANGLE_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_addr,
    input  logic [nasc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [nasc_pkg::DATA_W-1:0]  s_axis_tdata,   // [23:0] sample_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [nasc_pkg::DATA_W-1:0]  m_axis_tdata    // [23:0] sample_out
);
    import nasc_pkg::*;

    localparam int DIV_CELLS = QUO_W + 1;

    logic [CFG_W-1:0]  drive_reg;
    logic [CFG_W-1:0]  ceil_reg;
    logic [CFG_W-1:0]  k_val;

    logic              s0_valid_reg;
    logic              s0_ready;
    logic              s0_neg_reg;
    logic [DATA_W-1:0] s0_mag_reg;
    logic [DATA_W-1:0] s0_mag_next;

    logic              s1_valid_reg;
    logic              s1_ready;
    cordic_t           s1_reg;
    cordic_t           s1_next;
    logic [MAG_W-1:0]  m_prod;

    logic              cv [ANGLE_STAGES+1];
    logic              cr [ANGLE_STAGES+1];
    cordic_t           cd [ANGLE_STAGES+1];

    logic              p1_valid_reg;
    logic              p1_ready;
    logic              p1_neg_reg;
    logic [PROD_W-1:0] p1_prod_reg;
    logic [B_W-1:0]    p1_b_reg;
    logic [B_W-1:0]    a_val;
    logic [B_W-1:0]    b_val;

    logic              p2_valid_reg;
    logic              p2_ready;
    div_t              p2_reg;
    div_t              p2_next;

    logic              dv [DIV_CELLS+1];
    logic              dr [DIV_CELLS+1];
    div_t              dd [DIV_CELLS+1];

    logic              out_valid_reg;
    logic              out_ready;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic              over;
    logic [QUO_W-1:0]  mq;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= DRIVE_RESET;
            ceil_reg <= CEILING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DRIVE:   drive_reg <= cfg_data;
                REG_CEILING: ceil_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign k_val = (drive_reg == '0) ? CFG_W'(1) : drive_reg;

    // input register, magnitude and sign
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s_axis_tready = s0_ready;
    assign s0_mag_next = s_axis_tdata[DATA_W-1] ? (~s_axis_tdata + DATA_W'(1))
                                                : s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && s_axis_tvalid)
        begin
            s0_neg_reg <= s_axis_tdata[DATA_W-1];
            s0_mag_reg <= s0_mag_next;
        end
    end

    // drive product and cordic start vectors
    assign s1_ready = !s1_valid_reg || cr[0];
    assign m_prod = MAG_W'(k_val) * MAG_W'(s0_mag_reg);

    always_comb
    begin
        s1_next.neg = s0_neg_reg;
        s1_next.zero = (s0_mag_reg == '0);
        s1_next.va.x = X_START;
        s1_next.va.y = $signed(XY_W'(m_prod));
        s1_next.va.z = '0;
        s1_next.vb.x = X_START;
        s1_next.vb.y = $signed(XY_W'({k_val, {FRAC_W{1'b0}}}));
        s1_next.vb.z = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
        begin
            s1_reg <= s1_next;
        end
    end

    // cordic cell row
    assign cv[0] = s1_valid_reg;
    assign cd[0] = s1_reg;
    assign cr[ANGLE_STAGES] = p1_ready;

    for (genvar i = 0; i < ANGLE_STAGES; i++)
    begin : g_cordic
        nasc_cordic_cell #(
            .STAGE(i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .in_valid(cv[i]),
            .in_ready(cr[i]),
            .in_data(cd[i]),
            .out_valid(cv[i+1]),
            .out_ready(cr[i+1]),
            .out_data(cd[i+1])
        );
    end

    // clamp angles and scale by ceiling
    assign p1_ready = !p1_valid_reg || p2_ready;

    always_comb
    begin
        if (cd[ANGLE_STAGES].zero || cd[ANGLE_STAGES].va.z[Z_W-1])
        begin
            a_val = '0;
        end
        else
        begin
            a_val = cd[ANGLE_STAGES].va.z[B_W-1:0];
        end
        if (cd[ANGLE_STAGES].vb.z[Z_W-1] || cd[ANGLE_STAGES].vb.z == '0)
        begin
            b_val = B_W'(1);
        end
        else
        begin
            b_val = cd[ANGLE_STAGES].vb.z[B_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (p1_ready)
        begin
            p1_valid_reg <= cv[ANGLE_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && cv[ANGLE_STAGES])
        begin
            p1_neg_reg <= cd[ANGLE_STAGES].neg;
            p1_prod_reg <= PROD_W'(ceil_reg) * PROD_W'(a_val);
            p1_b_reg <= b_val;
        end
    end

    // rounding offset
    assign p2_ready = !p2_valid_reg || dr[0];

    always_comb
    begin
        p2_next.neg = p1_neg_reg;
        p2_next.sat = 1'b0;
        p2_next.r = NUM_W'({p1_prod_reg, 5'b0}) + NUM_W'(p1_b_reg >> 1);
        p2_next.b = p1_b_reg;
        p2_next.q = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (p2_ready)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_ready && p1_valid_reg)
        begin
            p2_reg <= p2_next;
        end
    end

    // division cell row, overflow check first
    assign dv[0] = p2_valid_reg;
    assign dd[0] = p2_reg;
    assign dr[DIV_CELLS] = out_ready;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        nasc_div_cell #(
            .SHIFT(QUO_W - j)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .in_valid(dv[j]),
            .in_ready(dr[j]),
            .in_data(dd[j]),
            .out_valid(dv[j+1]),
            .out_ready(dr[j+1]),
            .out_data(dd[j+1])
        );
    end

    // saturate, restore sign, output register
    assign out_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        over = dd[DIV_CELLS].sat ||
               (dd[DIV_CELLS].neg ? (dd[DIV_CELLS].q > SAT_NEG) : (dd[DIV_CELLS].q > SAT_POS));
        if (over)
        begin
            mq = dd[DIV_CELLS].neg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            mq = dd[DIV_CELLS].q;
        end
        out_data_next = dd[DIV_CELLS].neg ? DATA_W'(QUO_W'(0) - mq) : DATA_W'(mq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= dv[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && dv[DIV_CELLS])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

endmodule

/* rtl/nasc_checker.sv */
// port checker for the soft clipper and its bind
module nasc_checker #(
    parameter int ANGLE_STAGES = nasc_pkg::ANGLE_STAGES_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [nasc_pkg::DATA_W-1:0] m_axis_tdata
);
    import nasc_pkg::*;

    localparam int DEPTH = ANGLE_STAGES + QUO_W + 6;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // requests in flight
    always_comb
    begin
        count_next = count_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            count_next = count_next + CNT_W'(1);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count_reg != '0)
        else $error("result without pending request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> count_reg != '0)
        else $error("input stalled with empty pipeline");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind normalized_atan_soft_clipper nasc_checker #(
    .ANGLE_STAGES(ANGLE_STAGES)
) u_nasc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* tb/atan_clip_checker.sv */
// stream monitor, arctangent shaping predictor and result comparison for the soft clipper
`timescale 1ns / 1ps

module atan_clip_checker #(
    parameter int ANGLE_STAGES = nasc_pkg::ANGLE_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_addr,
    input  logic [nasc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [nasc_pkg::DATA_W-1:0]  s_axis_tdata,   // [23:0] sample_in
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [nasc_pkg::DATA_W-1:0]  m_axis_tdata,   // [23:0] sample_out
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);

    logic [nasc_pkg::CFG_W-1:0]  drive_q;
    logic [nasc_pkg::CFG_W-1:0]  ceiling_q;
    logic [nasc_pkg::DATA_W-1:0] expected_samples [$];

    // arctangent of m / 2^28 in q2.30, negative end angle clamped to zero
    function automatic longint atan_q30(input longint m);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint step_angle;
        int i;
        x = longint'(1) << 28;
        y = m;
        z = 0;
        if (m == 0)
            return 0;
        for (i = 0; i < ANGLE_STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            step_angle = {32'd0, nasc_pkg::ATAN_TAB[i]};
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step_angle;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step_angle;
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic logic [nasc_pkg::DATA_W-1:0] shaped_sample(
        input logic [nasc_pkg::DATA_W-1:0] raw,
        input logic [nasc_pkg::CFG_W-1:0]  k_reg,
        input logic [nasc_pkg::CFG_W-1:0]  c_reg
    );
        longint xv;
        longint mag;
        longint k;
        longint a;
        longint b;
        bit neg;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        xv = longint'(signed'(raw));
        neg = (xv < 0);
        mag = neg ? -xv : xv;
        k = {48'd0, k_reg};
        if (k == 0)
            k = 1;
        a = atan_q30(k * mag);
        b = atan_q30(k << 20);
        if (b <= 0)
            b = 1;
        num = {48'd0, c_reg};
        num = num * 64'(a) * 64'd32;
        den = 64'(b);
        q = (num + den / 2) / den;
        if (neg)
        begin
            if (q > 64'(nasc_pkg::SAT_NEG))
                q = 64'(nasc_pkg::SAT_NEG);
            q = 64'd0 - q;
        end
        else if (q > 64'(nasc_pkg::SAT_POS))
            q = 64'(nasc_pkg::SAT_POS);
        return q[nasc_pkg::DATA_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [nasc_pkg::DATA_W-1:0] want;
        if (!rst_n)
        begin
            drive_q <= nasc_pkg::DRIVE_RESET;
            ceiling_q <= nasc_pkg::CEILING_RESET;
            fail_count = 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_samples.push_back(shaped_sample(s_axis_tdata, drive_q, ceiling_q));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_samples.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (want !== m_axis_tdata)
                    begin
                        if (fail_count < 10)
                            $display("%0t: sample_out expected %h got %h",
                                     $realtime, want, m_axis_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == nasc_pkg::REG_DRIVE)
                    drive_q <= cfg_data;
                else if (cfg_addr == nasc_pkg::REG_CEILING)
                    ceiling_q <= cfg_data;
            end
            pending <= expected_samples.size();
        end
    end

endmodule

/* tb/tb_normalized_atan_soft_clipper.sv */
// top of the soft clipper testbench: clock, reset, register writes, sample stimulus and verdict
`timescale 1ns / 1ps

module tb_normalized_atan_soft_clipper;

    localparam int STAGES = nasc_pkg::ANGLE_STAGES_DEF;
    localparam int PHASES = 14;
    localparam int PHASE_SAMPLES = 125;
    localparam int HOLD_CYCLES = 300;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [0:0]                   cfg_addr = nasc_pkg::REG_DRIVE;
    logic [nasc_pkg::CFG_W-1:0]   cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [nasc_pkg::DATA_W-1:0]  s_axis_tdata = '0;   // [23:0] sample_in
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [nasc_pkg::DATA_W-1:0]  m_axis_tdata;        // [23:0] sample_out

    int fail_count;
    int pending;
    int results_seen;
    int samples_sent = 0;
    int settings_used = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_request = 1'b0;

    normalized_atan_soft_clipper #(.ANGLE_STAGES(STAGES)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    atan_clip_checker #(.ANGLE_STAGES(STAGES)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_normalized_atan_soft_clipper: done, errors");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = rx_idle_on ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    task automatic send_sample(input logic [nasc_pkg::DATA_W-1:0] value);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_levels(input logic [nasc_pkg::CFG_W-1:0] drive,
                              input logic [nasc_pkg::CFG_W-1:0] ceiling);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_addr <= nasc_pkg::REG_DRIVE;
        cfg_data <= drive;
        @(posedge clk);
        cfg_addr <= nasc_pkg::REG_CEILING;
        cfg_data <= ceiling;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [nasc_pkg::DATA_W-1:0] random_sample();
        int mag;
        logic [nasc_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = nasc_pkg::DATA_W'($urandom);
            2: v = nasc_pkg::DATA_W'($urandom_range(0, 4095));
            3: v = nasc_pkg::DATA_W'($urandom_range(0, 1 << 21));
            4: v = nasc_pkg::DATA_W'($urandom_range(0, 65535));
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = 24'h000000;
                    1: v = 24'h000001;
                    2: v = 24'hFFFFFF;
                    3: v = 24'h7FFFFF;
                    default: v = 24'h800000;
                endcase
                return v;
            end
        endcase
        mag = int'(v);
        if ($urandom_range(0, 1))
            v = nasc_pkg::DATA_W'(-mag);
        return v;
    endfunction

    initial
    begin
        int p;
        int n;
        logic [nasc_pkg::CFG_W-1:0] drive;
        logic [nasc_pkg::CFG_W-1:0] ceiling;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset levels: zero, extremes, unity and alternating bits
        send_sample(24'h000000);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h100000);
        send_sample(24'hF00000);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        settings_used++;

        // weakest drive, tiny operand may end at a negative angle
        set_levels(16'd1, 16'd32768);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);

        // drive of zero acts as the weakest drive, zero ceiling
        set_levels(16'd0, 16'd0);
        send_sample(24'h100000);
        send_sample(24'h800000);
        send_sample(24'h000000);

        // steepest drive with ceiling near two, saturating
        set_levels(16'hFFFF, 16'hFFFF);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h080000);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    drive = 16'd1;
                    ceiling = 16'd32768;
                end
                1:
                begin
                    drive = 16'hFFFF;
                    ceiling = 16'd32768;
                end
                2:
                begin
                    drive = 16'd0;
                    ceiling = 16'hFFFF;
                end
                3:
                begin
                    drive = 16'd256;
                    ceiling = 16'd0;
                end
                4:
                begin
                    drive = 16'hFFFF;
                    ceiling = 16'hFFFF;
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        drive = nasc_pkg::CFG_W'($urandom_range(1, 512));
                    else
                        drive = nasc_pkg::CFG_W'($urandom);
                    ceiling = nasc_pkg::CFG_W'($urandom);
                end
            endcase
            set_levels(drive, ceiling);
            tx_idle_on = (p % 4 != 2);
            rx_idle_on = (p % 4 != 3);
            if (p == 5)
            begin
                // receiver holds off while requests keep coming back to back
                tx_idle_on = 1'b0;
                hold_request = 1'b1;
            end
            for (n = 0; n < PHASE_SAMPLES; n++)
                send_sample(random_sample());
        end

        wait_idle();
        repeat (STAGES + 40) @(posedge clk);

        $display("%0d samples sent, %0d results checked", samples_sent, results_seen);
        $display("%0d drive/ceiling settings applied, random stalls on both sides",
                 settings_used);
        if (fail_count == 0 && pending == 0)
            $display("tb_normalized_atan_soft_clipper: done, clean");
        else
            $display("tb_normalized_atan_soft_clipper: done, errors");
        $finish;
    end

endmodule
